// ----- hw/rtl/pes_pkg.sv -----
// shared types, codes and widths for the pwm expander init and refresh sequencer
// no dependencies; pes_div and the top level refer to it by scoped names
package pes_pkg;

    localparam int CHANNELS = 16;
    localparam int OSC_HZ   = 25000000;

    localparam int FREQ_W = 11;
    localparam int MODE_W = 2;
    localparam int CHIN_W = 5;
    localparam int VAL_W  = 13;
    localparam int CNT_W  = 5;
    localparam int BYTE_W = 8;
    localparam int ST_W   = 2;
    localparam int STEP_W = 3;
    localparam int K_W    = 4;
    localparam int CH_W   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    // prescale = floor(osc / (4096 * f)) - 1 = floor(floor(osc / 4096) / f) - 1
    localparam int DIVIDEND = OSC_HZ / 4096;
    localparam int DVD_W    = $clog2(DIVIDEND + 1);
    localparam int DCNT_W   = $clog2(DVD_W + 1);
    localparam logic [FREQ_W-1:0] DEFAULT_FREQ = FREQ_W'(60);

    localparam logic [VAL_W-1:0] VAL_UNSET = '1;

    localparam logic [BYTE_W-1:0] REG_MODE1    = 8'h00;
    localparam logic [BYTE_W-1:0] REG_MODE2    = 8'h01;
    localparam logic [BYTE_W-1:0] REG_CH0      = 8'h06;
    localparam logic [BYTE_W-1:0] REG_ALL_ON_L = 8'hFA;
    localparam logic [BYTE_W-1:0] REG_PRESCALE = 8'hFE;
    localparam logic [BYTE_W-1:0] BIT_RESTART  = 8'h80;
    localparam logic [BYTE_W-1:0] BIT_SLEEP    = 8'h10;
    localparam logic [BYTE_W-1:0] BIT_OUTDRV   = 8'h04;
    localparam logic [BYTE_W-1:0] BIT_ALLCALL  = 8'h01;

    localparam logic [STEP_W-1:0] STEP_CLEAR    = 3'd0;
    localparam logic [STEP_W-1:0] STEP_READ     = 3'd1;
    localparam logic [STEP_W-1:0] STEP_RESTART  = 3'd2;
    localparam logic [STEP_W-1:0] STEP_PRESCALE = 3'd3;
    localparam logic [STEP_W-1:0] STEP_WAKE     = 3'd4;
    localparam logic [STEP_W-1:0] STEP_FINISHED = 3'd5;

    typedef enum logic [MODE_W-1:0] {
        MODE_REQUEST = 2'd0,
        MODE_REPLY   = 2'd1,
        MODE_SET     = 2'd2,
        MODE_GET     = 2'd3
    } mode_t;

    typedef enum logic [ST_W-1:0] {
        ST_SUCCESS       = 2'd0,
        ST_COMPLETED     = 2'd1,
        ST_NOT_CONNECTED = 2'd2,
        ST_FAILED        = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SINGLE,
        S_GET_WAIT,
        S_SCAN,
        S_DIV,
        S_EMIT
    } state_t;

    // which byte sequence the emitter walks through
    typedef enum logic [2:0] {
        K_CLEAR,
        K_READ,
        K_RESTART,
        K_PRESCALE,
        K_CHANNEL
    } kind_t;

    typedef struct packed {
        logic                done;
        logic [BYTE_W-1:0]   prescale;
    } div_res_t;

endpackage

// ----- hw/rtl/pes_ram.sv -----
// generic single write port, single read port ram with registered read
// no dependencies
module pes_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                       clk,
    input  logic                                       we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                           wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                           rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ----- hw/rtl/pes_div.sv -----
// bit-serial restoring divider for the prescale value, one quotient bit a cycle
// depends on pes_pkg
module pes_div (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [pes_pkg::FREQ_W-1:0]    divisor,
    output pes_pkg::div_res_t             res
);

    logic                          busy_reg, busy_next;
    logic                          done_reg, done_next;
    logic [pes_pkg::DCNT_W-1:0]    cnt_reg, cnt_next;
    logic [pes_pkg::FREQ_W-1:0]    rem_reg, rem_next;
    logic [pes_pkg::FREQ_W-1:0]    dsr_reg, dsr_next;
    logic [pes_pkg::DVD_W-1:0]     quo_reg, quo_next;
    logic [pes_pkg::FREQ_W:0]      trial;
    logic [pes_pkg::FREQ_W:0]      diff;
    logic                          fits;
    logic [pes_pkg::DVD_W-1:0]     quo_m1;

    // shift in the next dividend bit and try a subtract
    assign trial = {rem_reg, quo_reg[pes_pkg::DVD_W-1]};
    assign fits  = trial >= {1'b0, dsr_reg};
    assign diff  = trial - {1'b0, dsr_reg};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        dsr_next  = dsr_reg;
        quo_next  = quo_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            rem_next  = '0;
            dsr_next  = divisor;
            quo_next  = pes_pkg::DVD_W'(pes_pkg::DIVIDEND);
        end
        else if (busy_reg)
        begin
            rem_next = fits ? diff[pes_pkg::FREQ_W-1:0] : trial[pes_pkg::FREQ_W-1:0];
            quo_next = {quo_reg[pes_pkg::DVD_W-2:0], fits};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == pes_pkg::DCNT_W'(pes_pkg::DVD_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        dsr_reg <= dsr_next;
        quo_reg <= quo_next;
    end

    // quotient minus one, held to 0..255
    assign quo_m1 = quo_reg - 1'b1;

    always_comb
    begin
        res.done = done_reg;
        if (quo_reg == '0)
        begin
            res.prescale = '0;
        end
        else if (quo_m1 > pes_pkg::DVD_W'(255))
        begin
            res.prescale = 8'hFF;
        end
        else
        begin
            res.prescale = quo_m1[pes_pkg::BYTE_W-1:0];
        end
    end

endmodule

// ----- hw/rtl/pwm_expander_init_and_refresh_sequencer_unit.sv -----
// top level of the pwm expander init and refresh sequencer
// depends on pes_pkg, pes_ram (channel value store) and pes_div (prescale divider)
//
//  channel   ports                                        handshake
//  -------   -------------------------------------------  -------------------------------
//  config    freq_hz_we, freq_hz                          write when we high, no wait
//  item in   start, busy, mode, channel, channel_value,   taken when start && !busy
//            reply_count, reply_data
//  item out  result_strobe, out_byte, byte_valid,         one result per cycle, no stall
//            bus_read, last_byte, status, read_value
//
// items: reply and set give one result; get also waits on a store read when it can read the store;
// a start-up request emits its bytes (12 at most, one empty item when the mode read went unanswered),
// the prescale step runs the divider, then 6 bytes; a refresh request checks up to 16
// channels (one ram read a cycle), then emits 8 bytes or one empty item
// reset: control state clears; per-channel valid bits make an unwritten channel read as not set
// the receiver cannot stall: results go out one per cycle from the emit state
module pwm_expander_init_and_refresh_sequencer_unit (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               freq_hz_we,
    input  logic [pes_pkg::FREQ_W-1:0]         freq_hz,
    input  logic                               start,
    output logic                               busy,
    input  logic [pes_pkg::MODE_W-1:0]         mode,
    input  logic [pes_pkg::CHIN_W-1:0]         channel,
    input  logic signed [pes_pkg::VAL_W-1:0]   channel_value,
    input  logic [pes_pkg::CNT_W-1:0]          reply_count,
    input  logic [pes_pkg::BYTE_W-1:0]         reply_data,
    output logic                               result_strobe,
    output logic [pes_pkg::BYTE_W-1:0]         out_byte,
    output logic                               byte_valid,
    output logic                               bus_read,
    output logic                               last_byte,
    output logic [pes_pkg::ST_W-1:0]           status,
    output logic signed [pes_pkg::VAL_W-1:0]   read_value
);

    // sequencer state
    pes_pkg::state_t                   state_reg, state_next;
    pes_pkg::kind_t                    kind_reg, kind_next;
    pes_pkg::status_t                  status_reg, status_next;
    logic [pes_pkg::K_W-1:0]           k_reg, k_next;        // byte index being emitted
    logic [pes_pkg::K_W-1:0]           n_reg, n_next;        // index of the last byte
    logic                              rd_reg, rd_next;
    logic [pes_pkg::VAL_W-1:0]         rv_reg, rv_next;
    logic                              gvalid_reg, gvalid_next;
    logic [pes_pkg::CH_W:0]            left_reg, left_next;  // channels left to check
    logic                              wrap_reg, wrap_next;
    logic [pes_pkg::VAL_W-1:0]         val_reg, val_next;
    logic [pes_pkg::BYTE_W-1:0]        base_reg, base_next;

    // architectural state
    logic [pes_pkg::FREQ_W-1:0]        freq_reg, freq_next;
    logic [pes_pkg::STEP_W-1:0]        step_reg, step_next;
    logic [pes_pkg::CH_W-1:0]          sp_reg, sp_next;      // rotating scan pointer
    logic [pes_pkg::BYTE_W-1:0]        saved_reg, saved_next;
    logic [pes_pkg::BYTE_W-1:0]        held_reg, held_next;
    logic                              present_reg, present_next;
    logic [pes_pkg::CHANNELS-1:0]      valid_reg, valid_next;

    logic                              accept;
    logic                              ch_ok;
    logic [pes_pkg::CH_W-1:0]          ch_idx;
    logic                              finished;
    logic                              p_last;
    logic [pes_pkg::CH_W-1:0]          p_inc;
    logic                              found;
    logic                              ram_we;
    logic [pes_pkg::CH_W-1:0]          ram_raddr;
    logic [pes_pkg::VAL_W-1:0]         ram_rdata;
    logic                              div_start;
    logic [pes_pkg::FREQ_W-1:0]        div_divisor;
    pes_pkg::div_res_t                 div_res;
    logic [pes_pkg::BYTE_W-1:0]        emit_byte;

    assign busy     = state_reg != pes_pkg::S_IDLE;
    assign accept   = start && !busy;
    assign ch_ok    = channel < pes_pkg::CHIN_W'(pes_pkg::CHANNELS);
    assign ch_idx   = channel[pes_pkg::CH_W-1:0];
    assign finished = step_reg >= pes_pkg::STEP_FINISHED;

    // scan pointer advance with wrap at the channel count
    assign p_last = sp_reg == pes_pkg::CH_W'(pes_pkg::CHANNELS - 1);
    assign p_inc  = p_last ? '0 : sp_reg + 1'b1;
    // a channel holds a value when written and not negative
    assign found  = valid_reg[sp_reg] && !ram_rdata[pes_pkg::VAL_W-1];

    // read the next channel while checking the current one
    assign ram_raddr = (state_reg == pes_pkg::S_SCAN) ? p_inc :
                       (mode == pes_pkg::MODE_GET)    ? ch_idx : sp_reg;
    assign ram_we    = accept && (mode == pes_pkg::MODE_SET) && ch_ok;

    pes_ram #(
        .WIDTH (pes_pkg::VAL_W),
        .DEPTH (pes_pkg::CHANNELS)
    ) u_values (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ch_idx),
        .wdata (channel_value),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign div_start   = accept && (mode == pes_pkg::MODE_REQUEST)
                         && (step_reg == pes_pkg::STEP_PRESCALE);
    assign div_divisor = (freq_reg == '0) ? pes_pkg::DEFAULT_FREQ : freq_reg;

    pes_div u_div (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (div_start),
        .divisor (div_divisor),
        .res     (div_res)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            pes_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    case (mode)
                        pes_pkg::MODE_REPLY,
                        pes_pkg::MODE_SET:
                        begin
                            state_next = pes_pkg::S_SINGLE;
                        end
                        pes_pkg::MODE_GET:
                        begin
                            state_next = (ch_ok && step_reg == pes_pkg::STEP_FINISHED)
                                         ? pes_pkg::S_GET_WAIT : pes_pkg::S_SINGLE;
                        end
                        default:
                        begin
                            if (finished)
                            begin
                                state_next = pes_pkg::S_SCAN;
                            end
                            else if (step_reg == pes_pkg::STEP_RESTART && !present_reg)
                            begin
                                state_next = pes_pkg::S_SINGLE;
                            end
                            else if (step_reg == pes_pkg::STEP_PRESCALE)
                            begin
                                state_next = pes_pkg::S_DIV;
                            end
                            else
                            begin
                                state_next = pes_pkg::S_EMIT;
                            end
                        end
                    endcase
                end
            end
            pes_pkg::S_GET_WAIT:
            begin
                state_next = pes_pkg::S_SINGLE;
            end
            pes_pkg::S_SINGLE:
            begin
                state_next = pes_pkg::S_IDLE;
            end
            pes_pkg::S_DIV:
            begin
                if (div_res.done)
                begin
                    state_next = pes_pkg::S_EMIT;
                end
            end
            pes_pkg::S_SCAN:
            begin
                if (found)
                begin
                    state_next = pes_pkg::S_EMIT;
                end
                else if (left_reg == (pes_pkg::CH_W + 1)'(1))
                begin
                    state_next = pes_pkg::S_SINGLE;
                end
            end
            pes_pkg::S_EMIT:
            begin
                if (k_reg == n_reg)
                begin
                    state_next = pes_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = pes_pkg::S_IDLE;
            end
        endcase
    end

    // datapath registers
    always_comb
    begin
        kind_next    = kind_reg;
        status_next  = status_reg;
        k_next       = k_reg;
        n_next       = n_reg;
        rd_next      = rd_reg;
        rv_next      = rv_reg;
        gvalid_next  = gvalid_reg;
        left_next    = left_reg;
        wrap_next    = wrap_reg;
        val_next     = val_reg;
        base_next    = base_reg;
        freq_next    = freq_hz_we ? freq_hz : freq_reg;
        step_next    = step_reg;
        sp_next      = sp_reg;
        saved_next   = saved_reg;
        held_next    = held_reg;
        present_next = present_reg;
        valid_next   = valid_reg;

        case (state_reg)
            pes_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    k_next  = '0;
                    rd_next = 1'b0;
                    rv_next = '0;
                    case (mode)
                        pes_pkg::MODE_REPLY:
                        begin
                            // only a one or two byte reply counts
                            if (reply_count >= pes_pkg::CNT_W'(1)
                                && reply_count <= pes_pkg::CNT_W'(2))
                            begin
                                held_next    = reply_data;
                                present_next = 1'b1;
                            end
                            status_next = pes_pkg::ST_COMPLETED;
                        end
                        pes_pkg::MODE_SET:
                        begin
                            if (!ch_ok)
                            begin
                                status_next = pes_pkg::ST_FAILED;
                            end
                            else
                            begin
                                valid_next[ch_idx] = 1'b1;
                                status_next = (step_reg == pes_pkg::STEP_FINISHED)
                                              ? pes_pkg::ST_SUCCESS
                                              : pes_pkg::ST_NOT_CONNECTED;
                            end
                        end
                        pes_pkg::MODE_GET:
                        begin
                            status_next = pes_pkg::ST_SUCCESS;
                            rv_next     = pes_pkg::VAL_UNSET;
                            gvalid_next = valid_reg[ch_idx];
                        end
                        default:
                        begin
                            status_next = pes_pkg::ST_SUCCESS;
                            case (step_reg)
                                pes_pkg::STEP_CLEAR:
                                begin
                                    kind_next = pes_pkg::K_CLEAR;
                                    n_next    = pes_pkg::K_W'(11);
                                    step_next = pes_pkg::STEP_READ;
                                end
                                pes_pkg::STEP_READ:
                                begin
                                    kind_next    = pes_pkg::K_READ;
                                    n_next       = pes_pkg::K_W'(1);
                                    rd_next      = 1'b1;
                                    present_next = 1'b0;
                                    step_next    = pes_pkg::STEP_RESTART;
                                end
                                pes_pkg::STEP_RESTART:
                                begin
                                    if (!present_reg)
                                    begin
                                        // device never answered the mode read
                                        status_next = pes_pkg::ST_NOT_CONNECTED;
                                        step_next   = pes_pkg::STEP_CLEAR;
                                    end
                                    else
                                    begin
                                        saved_next = held_reg & ~pes_pkg::BIT_RESTART;
                                        kind_next  = pes_pkg::K_RESTART;
                                        n_next     = pes_pkg::K_W'(1);
                                        step_next  = pes_pkg::STEP_PRESCALE;
                                    end
                                end
                                pes_pkg::STEP_PRESCALE:
                                begin
                                    kind_next = pes_pkg::K_PRESCALE;
                                    n_next    = pes_pkg::K_W'(5);
                                    step_next = pes_pkg::STEP_WAKE;
                                end
                                pes_pkg::STEP_WAKE:
                                begin
                                    kind_next = pes_pkg::K_RESTART;
                                    n_next    = pes_pkg::K_W'(1);
                                    step_next = pes_pkg::STEP_FINISHED;
                                end
                                default:
                                begin
                                    // refresh scan
                                    left_next = (pes_pkg::CH_W + 1)'(pes_pkg::CHANNELS);
                                    wrap_next = 1'b0;
                                end
                            endcase
                        end
                    endcase
                end
            end
            pes_pkg::S_GET_WAIT:
            begin
                rv_next = gvalid_reg ? ram_rdata : pes_pkg::VAL_UNSET;
            end
            pes_pkg::S_SCAN:
            begin
                sp_next   = p_inc;
                left_next = left_reg - 1'b1;
                wrap_next = wrap_reg || p_last;
                if (found)
                begin
                    kind_next   = pes_pkg::K_CHANNEL;
                    n_next      = pes_pkg::K_W'(7);
                    val_next    = ram_rdata;
                    base_next   = pes_pkg::BYTE_W'({sp_reg, 2'b00}) + pes_pkg::REG_CH0;
                    status_next = (wrap_reg || p_last) ? pes_pkg::ST_COMPLETED
                                                       : pes_pkg::ST_SUCCESS;
                end
                else
                begin
                    // nothing set anywhere: the scan went all the way round
                    status_next = pes_pkg::ST_COMPLETED;
                end
            end
            pes_pkg::S_EMIT:
            begin
                k_next = k_reg + 1'b1;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= pes_pkg::S_IDLE;
            freq_reg    <= '0;
            step_reg    <= pes_pkg::STEP_CLEAR;
            sp_reg      <= '0;
            saved_reg   <= '0;
            held_reg    <= '0;
            present_reg <= 1'b0;
            valid_reg   <= '0;
            k_reg       <= '0;
            n_reg       <= '0;
            left_reg    <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            freq_reg    <= freq_next;
            step_reg    <= step_next;
            sp_reg      <= sp_next;
            saved_reg   <= saved_next;
            held_reg    <= held_next;
            present_reg <= present_next;
            valid_reg   <= valid_next;
            k_reg       <= k_next;
            n_reg       <= n_next;
            left_reg    <= left_next;
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg   <= kind_next;
        status_reg <= status_next;
        rd_reg     <= rd_next;
        rv_reg     <= rv_next;
        gvalid_reg <= gvalid_next;
        wrap_reg   <= wrap_next;
        val_reg    <= val_next;
        base_reg   <= base_next;
    end

    // byte at index k of the current sequence
    always_comb
    begin
        emit_byte = '0;
        case (kind_reg)
            pes_pkg::K_CLEAR:
            begin
                // four all-led registers zeroed, then mode2 and mode1
                if (k_reg < pes_pkg::K_W'(8))
                begin
                    emit_byte = k_reg[0] ? '0
                              : pes_pkg::REG_ALL_ON_L + pes_pkg::BYTE_W'(k_reg[2:1]);
                end
                else
                begin
                    case (k_reg[1:0])
                        2'd0:    emit_byte = pes_pkg::REG_MODE2;
                        2'd1:    emit_byte = pes_pkg::BIT_OUTDRV;
                        2'd2:    emit_byte = pes_pkg::REG_MODE1;
                        default: emit_byte = pes_pkg::BIT_ALLCALL;
                    endcase
                end
            end
            pes_pkg::K_READ:
            begin
                emit_byte = k_reg[0] ? pes_pkg::REG_MODE2 : pes_pkg::REG_MODE1;
            end
            pes_pkg::K_RESTART:
            begin
                emit_byte = k_reg[0] ? (pes_pkg::BIT_RESTART | saved_reg) : pes_pkg::REG_MODE1;
            end
            pes_pkg::K_PRESCALE:
            begin
                case (k_reg)
                    pes_pkg::K_W'(0): emit_byte = pes_pkg::REG_MODE1;
                    pes_pkg::K_W'(1): emit_byte = pes_pkg::BIT_SLEEP | saved_reg;
                    pes_pkg::K_W'(2): emit_byte = pes_pkg::REG_PRESCALE;
                    pes_pkg::K_W'(3): emit_byte = div_res.prescale;
                    pes_pkg::K_W'(4): emit_byte = pes_pkg::REG_MODE1;
                    default:          emit_byte = saved_reg;
                endcase
            end
            pes_pkg::K_CHANNEL:
            begin
                // on low, on high, off low, off high
                if (!k_reg[0])
                begin
                    emit_byte = base_reg + pes_pkg::BYTE_W'(k_reg[2:1]);
                end
                else
                begin
                    case (k_reg[2:1])
                        2'd2:    emit_byte = val_reg[7:0];
                        2'd3:    emit_byte = pes_pkg::BYTE_W'(val_reg[pes_pkg::VAL_W-1:8]);
                        default: emit_byte = '0;
                    endcase
                end
            end
            default:
            begin
                emit_byte = '0;
            end
        endcase
    end

    // result ports
    always_comb
    begin
        result_strobe = 1'b0;
        out_byte      = '0;
        byte_valid    = 1'b0;
        bus_read      = 1'b0;
        last_byte     = 1'b0;
        status        = '0;
        read_value    = '0;
        case (state_reg)
            pes_pkg::S_SINGLE:
            begin
                result_strobe = 1'b1;
                last_byte     = 1'b1;
                status        = status_reg;
                read_value    = rv_reg;
            end
            pes_pkg::S_EMIT:
            begin
                result_strobe = 1'b1;
                out_byte      = emit_byte;
                byte_valid    = 1'b1;
                bus_read      = rd_reg;
                last_byte     = k_reg == n_reg;
                status        = status_reg;
            end
            default:
            begin
            end
        endcase
    end

    // results only come out while an item is in flight
    a_strobe_busy: assert property (@(posedge clk) disable iff (!rst_n)
        result_strobe |-> busy)
        else $error("result strobe while idle");

    // after the last result of an item the block is ready again
    a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (result_strobe && last_byte) |=> !busy)
        else $error("block still busy after last result");

    // an empty result is always the only one of its item
    a_empty_last: assert property (@(posedge clk) disable iff (!rst_n)
        (result_strobe && !byte_valid) |-> last_byte)
        else $error("empty result not marked last");

    // the start-up step never passes finished
    a_step_range: assert property (@(posedge clk) disable iff (!rst_n)
        step_reg <= pes_pkg::STEP_FINISHED)
        else $error("start-up step out of range");

    // the prescale byte is only sent once the divider has finished
    a_div_done: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == pes_pkg::S_DIV && div_res.done) |=> state_reg == pes_pkg::S_EMIT)
        else $error("divider result not followed by emit");

endmodule
